[rtl/bpc_pkg.sv]
// Package for the button press classifier: widths, codes, state type and
// the shared time compare result. No dependencies.
`default_nettype none
package bpc_pkg;
	localparam int MAX_BUTTONS = 8;
	localparam int IDX_W       = $clog2(MAX_BUTTONS);
	localparam int CNT_W       = 4;
	localparam int TIME_W      = 31;
	localparam int MS_W        = 16;
	localparam int SUM_W       = 33;
	localparam int CODE_W      = 8;
	localparam int CODES_W     = CODE_W * MAX_BUTTONS;
	localparam int FLAG_W      = 4;
	localparam int LEVELS_W    = 8;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 64;

	// flag bit positions
	localparam int FLAG_PRESSED = 0;
	localparam int FLAG_SHORT   = 1;
	localparam int FLAG_LONG    = 2;
	localparam int FLAG_REPEAT  = 3;

	localparam logic OP_SCAN  = 1'b0;
	localparam logic OP_FETCH = 1'b1;

	localparam logic [CNT_W-1:0] RST_BUTTON_COUNT = CNT_W'(8);
	localparam logic [MS_W-1:0]  RST_REPEAT_DELAY = MS_W'(500);
	localparam logic [MS_W-1:0]  RST_REPEAT_GAP   = MS_W'(100);
	localparam logic [MS_W-1:0]  RST_LONG_PRESS   = MS_W'(1000);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BUTTON_COUNT,
		CFG_REPEAT_DELAY,
		CFG_REPEAT_INTERVAL,
		CFG_LONG_PRESS,
		CFG_SHORT_CODES,
		CFG_LONG_CODES
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FETCH,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic hold_over;
		logic gap_over;
	} time_cmp_t;
endpackage
`default_nettype wire

[rtl/bpc_stream_if.sv]
// Request and response channel interfaces of the button press classifier.
// Depends on bpc_pkg.
`default_nettype none
interface bpc_req_if;
	logic                           valid;
	logic                           ready;
	logic                           operation;
	logic [bpc_pkg::TIME_W-1:0]     now_ms;
	logic [bpc_pkg::LEVELS_W-1:0]   button_levels;

	modport source(output valid, operation, now_ms, button_levels, input ready);
	modport sink(input valid, operation, now_ms, button_levels, output ready);
endinterface

interface bpc_rsp_if;
	logic                         valid;
	logic                         ready;
	logic                         pending;
	logic                         event_valid;
	logic [bpc_pkg::CODE_W-1:0]   key_code;

	modport source(output valid, pending, event_valid, key_code, input ready);
	modport sink(input valid, pending, event_valid, key_code, output ready);
endinterface
`default_nettype wire

[rtl/bpc_time_cmp.sv]
// Shared time compare unit: checks hold time and repeat gap against now.
// Depends on bpc_pkg.
`default_nettype none
module bpc_time_cmp (
	input  wire logic [bpc_pkg::TIME_W-1:0] now_ms,
	input  wire logic [bpc_pkg::TIME_W-1:0] press_ms,
	input  wire logic [bpc_pkg::TIME_W-1:0] repeat_ms,
	input  wire logic [bpc_pkg::MS_W-1:0]   hold_ms,
	input  wire logic [bpc_pkg::MS_W-1:0]   gap_ms,
	output bpc_pkg::time_cmp_t              res
);
	logic [bpc_pkg::SUM_W-1:0] now_ext;
	logic [bpc_pkg::SUM_W-1:0] hold_sum;
	logic [bpc_pkg::SUM_W-1:0] gap_sum;

	always_comb begin
		now_ext  = {{(bpc_pkg::SUM_W-bpc_pkg::TIME_W){1'b0}}, now_ms};
		hold_sum = {{(bpc_pkg::SUM_W-bpc_pkg::TIME_W){1'b0}}, press_ms}
			+ {{(bpc_pkg::SUM_W-bpc_pkg::MS_W){1'b0}}, hold_ms};
		gap_sum  = {{(bpc_pkg::SUM_W-bpc_pkg::TIME_W){1'b0}}, repeat_ms}
			+ {{(bpc_pkg::SUM_W-bpc_pkg::MS_W){1'b0}}, gap_ms};
		res.hold_over = now_ext > hold_sum;
		res.gap_over  = now_ext > gap_sum;
	end
endmodule
`default_nettype wire

[rtl/button_press_classifier.sv]
// Button press classifier top level: sequencer, flag store, config registers.
// Depends on bpc_pkg, bpc_stream_if, bpc_time_cmp.
//
//   channel  dir  beat payload                             handshake
//   req      in   operation, now_ms, button_levels         valid/ready
//   rsp      out  pending, event_valid, key_code           valid/ready
//   config   in   write_en, reg_index, write_data          write_en only
//
// One button is visited per cycle through the shared time compare unit.
// A scan passes through accept, one step for each button in use and result load,
// in that order; a fetch stops at the first flagged button or after the last one.
// req.ready is high only when the sequencer is idle; the result register holds
// a beat while rsp stalls and the next item is accepted meanwhile.
// Reset clears all flags, both timestamps and restores config defaults.
`default_nettype none
module button_press_classifier (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	bpc_req_if.sink                                req,
	bpc_rsp_if.source                              rsp,
	input  wire logic                              write_en,
	input  wire logic [bpc_pkg::CFG_IDX_W-1:0]     reg_index,
	input  wire logic [bpc_pkg::CFG_DATA_W-1:0]    write_data
);
	bpc_pkg::state_t state_q, state_d;

	logic [bpc_pkg::CNT_W-1:0]   count_q;
	logic [bpc_pkg::MS_W-1:0]    delay_q;
	logic [bpc_pkg::MS_W-1:0]    gap_q;
	logic [bpc_pkg::MS_W-1:0]    long_q;
	logic [bpc_pkg::CODES_W-1:0] short_codes_q;
	logic [bpc_pkg::CODES_W-1:0] long_codes_q;

	logic [bpc_pkg::FLAG_W-1:0]  flags_q [bpc_pkg::MAX_BUTTONS];
	logic [bpc_pkg::TIME_W-1:0]  press_q;
	logic [bpc_pkg::TIME_W-1:0]  repeat_q;
	logic [bpc_pkg::IDX_W-1:0]   idx_q;

	logic                          op_q;
	logic [bpc_pkg::TIME_W-1:0]    now_q;
	logic [bpc_pkg::LEVELS_W-1:0]  levels_q;
	logic                          pend_q;
	logic                          hit_q;
	logic [bpc_pkg::CODE_W-1:0]    code_q;

	logic                          rsp_valid_q;
	logic                          rsp_pending_q;
	logic                          rsp_event_q;
	logic [bpc_pkg::CODE_W-1:0]    rsp_code_q;

	logic [bpc_pkg::CNT_W-1:0]     n_use;
	logic                          last_btn;
	logic                          slot_free;
	logic                          accept;
	logic                          req_ready;
	logic                          step_scan;
	logic                          step_fetch;
	logic                          load_out;

	logic                          down;
	logic [bpc_pkg::FLAG_W-1:0]    f_cur;
	logic [bpc_pkg::FLAG_W-1:0]    f_new;
	logic                          set_times;
	logic                          set_repeat;
	logic                          step_pend;
	logic                          f_hit;
	logic                          f_clear;
	logic [bpc_pkg::CODE_W-1:0]    f_code;
	logic [bpc_pkg::MS_W-1:0]      hold_sel;
	bpc_pkg::time_cmp_t            cmp;

	bpc_time_cmp u_time_cmp (
		.now_ms    (now_q),
		.press_ms  (press_q),
		.repeat_ms (repeat_q),
		.hold_ms   (hold_sel),
		.gap_ms    (gap_q),
		.res       (cmp)
	);

	always_comb begin
		n_use = (count_q > bpc_pkg::CNT_W'(bpc_pkg::MAX_BUTTONS))
			? bpc_pkg::CNT_W'(bpc_pkg::MAX_BUTTONS) : count_q;
		last_btn  = (bpc_pkg::CNT_W'(idx_q) + bpc_pkg::CNT_W'(1)) == n_use;
		slot_free = !rsp_valid_q || rsp.ready;
		accept    = req.valid && req_ready;
	end

	// per-button step
	always_comb begin
		down     = levels_q[idx_q];
		f_cur    = flags_q[idx_q];
		hold_sel = down ? delay_q : long_q;
		f_new      = f_cur;
		set_times  = 1'b0;
		set_repeat = 1'b0;
		step_pend  = 1'b0;
		if (down && f_cur == '0) begin
			f_new[bpc_pkg::FLAG_PRESSED] = 1'b1;
			set_times = 1'b1;
		end else if (down && f_cur[bpc_pkg::FLAG_PRESSED]) begin
			if (cmp.hold_over && cmp.gap_over) begin
				f_new[bpc_pkg::FLAG_REPEAT] = 1'b1;
				set_repeat = 1'b1;
				step_pend  = 1'b1;
			end
		end else if (!down && f_cur[bpc_pkg::FLAG_PRESSED]) begin
			if (f_cur[bpc_pkg::FLAG_REPEAT]) begin
				f_new = '0;
			end else begin
				if (cmp.hold_over)
					f_new[bpc_pkg::FLAG_LONG] = 1'b1;
				else
					f_new[bpc_pkg::FLAG_SHORT] = 1'b1;
				step_pend = 1'b1;
			end
		end

		f_hit   = 1'b0;
		f_clear = 1'b0;
		f_code  = '0;
		if (f_cur[bpc_pkg::FLAG_SHORT]) begin
			f_hit   = 1'b1;
			f_clear = 1'b1;
			f_code  = short_codes_q[idx_q*bpc_pkg::CODE_W +: bpc_pkg::CODE_W];
		end else if (f_cur[bpc_pkg::FLAG_LONG]) begin
			f_hit   = 1'b1;
			f_clear = 1'b1;
			f_code  = long_codes_q[idx_q*bpc_pkg::CODE_W +: bpc_pkg::CODE_W];
		end else if (f_cur[bpc_pkg::FLAG_REPEAT]) begin
			f_hit  = 1'b1;
			f_code = short_codes_q[idx_q*bpc_pkg::CODE_W +: bpc_pkg::CODE_W];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bpc_pkg::ST_IDLE: begin
				if (req.valid) begin
					if (n_use == '0)
						state_d = bpc_pkg::ST_FINISH;
					else if (req.operation == bpc_pkg::OP_FETCH)
						state_d = bpc_pkg::ST_FETCH;
					else
						state_d = bpc_pkg::ST_SCAN;
				end
			end
			bpc_pkg::ST_SCAN: begin
				if (last_btn)
					state_d = bpc_pkg::ST_FINISH;
			end
			bpc_pkg::ST_FETCH: begin
				if (f_hit || last_btn)
					state_d = bpc_pkg::ST_FINISH;
			end
			bpc_pkg::ST_FINISH: begin
				if (slot_free)
					state_d = bpc_pkg::ST_IDLE;
			end
			default: state_d = bpc_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		req_ready  = 1'b0;
		step_scan  = 1'b0;
		step_fetch = 1'b0;
		load_out   = 1'b0;
		case (state_q)
			bpc_pkg::ST_IDLE:   req_ready  = 1'b1;
			bpc_pkg::ST_SCAN:   step_scan  = 1'b1;
			bpc_pkg::ST_FETCH:  step_fetch = 1'b1;
			bpc_pkg::ST_FINISH: load_out   = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= bpc_pkg::ST_IDLE;
			count_q       <= bpc_pkg::RST_BUTTON_COUNT;
			delay_q       <= bpc_pkg::RST_REPEAT_DELAY;
			gap_q         <= bpc_pkg::RST_REPEAT_GAP;
			long_q        <= bpc_pkg::RST_LONG_PRESS;
			short_codes_q <= '0;
			long_codes_q  <= '0;
			for (int i = 0; i < bpc_pkg::MAX_BUTTONS; i++)
				flags_q[i] <= '0;
			press_q     <= '0;
			repeat_q    <= '0;
			idx_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (write_en) begin
				case (bpc_pkg::cfg_reg_t'(reg_index))
					bpc_pkg::CFG_BUTTON_COUNT:
						count_q <= write_data[bpc_pkg::CNT_W-1:0];
					bpc_pkg::CFG_REPEAT_DELAY:
						delay_q <= write_data[bpc_pkg::MS_W-1:0];
					bpc_pkg::CFG_REPEAT_INTERVAL:
						gap_q <= write_data[bpc_pkg::MS_W-1:0];
					bpc_pkg::CFG_LONG_PRESS:
						long_q <= write_data[bpc_pkg::MS_W-1:0];
					bpc_pkg::CFG_SHORT_CODES:
						short_codes_q <= write_data[bpc_pkg::CODES_W-1:0];
					bpc_pkg::CFG_LONG_CODES:
						long_codes_q <= write_data[bpc_pkg::CODES_W-1:0];
					default: ;
				endcase
			end
			if (accept)
				idx_q <= '0;
			else if (step_scan || step_fetch)
				idx_q <= idx_q + bpc_pkg::IDX_W'(1);
			if (step_scan) begin
				flags_q[idx_q] <= f_new;
				if (set_times)
					press_q <= now_q;
				if (set_times || set_repeat)
					repeat_q <= now_q;
			end
			if (step_fetch && f_clear)
				flags_q[idx_q] <= '0;
			if (load_out)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= req.operation;
			now_q    <= req.now_ms;
			levels_q <= req.button_levels;
			pend_q   <= 1'b0;
			hit_q    <= 1'b0;
			code_q   <= '0;
		end else begin
			if (step_scan && step_pend)
				pend_q <= 1'b1;
			if (step_fetch && f_hit) begin
				hit_q  <= 1'b1;
				code_q <= f_code;
			end
		end
		if (load_out) begin
			rsp_pending_q <= pend_q && (op_q == bpc_pkg::OP_SCAN);
			rsp_event_q   <= hit_q;
			rsp_code_q    <= code_q;
		end
	end

	assign req.ready       = req_ready;
	assign rsp.valid       = rsp_valid_q;
	assign rsp.pending     = rsp_pending_q;
	assign rsp.event_valid = rsp_event_q;
	assign rsp.key_code    = rsp_code_q;
endmodule
`default_nettype wire

[rtl/bpc_checker.sv]
// Port-level checks for the button press classifier, bound to the top level.
// Depends on bpc_pkg and button_press_classifier.
`default_nettype none
module bpc_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         req_valid,
	input wire logic                         req_ready,
	input wire logic                         rsp_valid,
	input wire logic                         rsp_ready,
	input wire logic                         rsp_pending,
	input wire logic                         rsp_event_valid,
	input wire logic [bpc_pkg::CODE_W-1:0]   rsp_key_code
);
	// a beat in takes the sequencer busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("req ready right after an accepted beat");

	a_no_event_no_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_event_valid |-> rsp_key_code == '0)
		else $error("key code without event");

	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_pending && rsp_event_valid))
		else $error("pending and event_valid both set");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pending)
			&& $stable(rsp_event_valid) && $stable(rsp_key_code))
		else $error("stalled rsp beat changed");
endmodule

bind button_press_classifier bpc_checker u_bpc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_pending     (rsp.pending),
	.rsp_event_valid (rsp.event_valid),
	.rsp_key_code    (rsp.key_code)
);
`default_nettype wire
